// ===== hdl/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the decimal ASCII converter
// Holds the value width, the digit register layout, the ASCII code for zero
// and the sequencer state type.
// ----------------------------------------------------------------------------
package bda_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int CNT_W       = $clog2(VALUE_WIDTH);
   localparam int MAX_DIGITS  = 20;
   localparam int BCD_W       = 4 * MAX_DIGITS;
   localparam int NDIG_W      = $clog2(MAX_DIGITS + 1);
   localparam int LEN_W       = 6;
   localparam int CHAR_W      = 6;
   localparam int REQ_DATA_W  = ((VALUE_WIDTH + LEN_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_TRIM,
      ST_EMIT
   } state_type;

endpackage

// ===== hdl/binary_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit: unsigned binary to decimal ASCII digits
// Converts one value with a shift-and-add-3 unit, one bit per cycle, strips
// leading zeros and then streams the digits most significant first, or a
// single failure result when the digits and a terminator do not fit.
// ----------------------------------------------------------------------------
// Steps: accept the request, convert the value bit by bit, then strip leading
// zeros and check the length against the buffer, n = digit count.
// Results follow at one per cycle while rsp_tready is high: n digits, or one failure result.
// No new request is taken until the last result has been accepted.
// Reset clears the sequencer only; the data registers are not reset.
module binary_to_decimal_ascii_unit (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: value [63:0], buffer_length [69:64], zero fill above
   input  logic [bda_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: digit_char [5:0], zero fill above
   output logic [bda_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: ok [0]
   output logic [0:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);
   import bda_pkg::*;

   state_type               state_ff, state_in;
   logic [VALUE_WIDTH-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]        bcd_ff, bcd_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [NDIG_W-1:0]       ndig_ff, ndig_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    fail_ff, fail_in;

   logic                    req_fire;
   logic                    rsp_fire;
   logic                    conv_done;
   logic                    top_zero;
   logic                    last_item;
   logic [3:0]              top_nib;
   logic [BCD_W-1:0]        bcd_adj;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign conv_done = (cnt_ff == CNT_W'(VALUE_WIDTH - 1));
   assign top_nib   = bcd_ff[BCD_W-1 -: 4];
   assign top_zero  = (top_nib == 4'd0) && (ndig_ff > NDIG_W'(1));
   assign last_item = fail_ff || (ndig_ff == NDIG_W'(1));

   // Add 3 to every decimal digit of 5 or more before the next left shift.
   always_comb begin
      logic [3:0] nib;
      bcd_adj = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         nib = bcd_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (conv_done) state_in = ST_TRIM;
         end
         ST_TRIM: begin
            if (!top_zero) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire && last_item) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_EMIT: rsp_tvalid = 1'b1;
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
      rsp_tdata    = '0;
      rsp_tdata[CHAR_W-1:0] = fail_ff ? '0 : ASCII_ZERO + CHAR_W'(top_nib);
      rsp_tuser[0] = !fail_ff;
      rsp_tlast    = last_item;
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      ndig_in = ndig_ff;
      len_in  = len_ff;
      fail_in = fail_ff;
      case (state_ff)
         ST_IDLE: begin
            bin_in = req_tdata[VALUE_WIDTH-1:0];
            len_in = req_tdata[VALUE_WIDTH +: LEN_W];
            bcd_in = '0;
            cnt_in = '0;
         end
         ST_CONV: begin
            bcd_in  = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in  = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff + CNT_W'(1);
            ndig_in = NDIG_W'(MAX_DIGITS);
         end
         ST_TRIM: begin
            if (top_zero) begin
               bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
               ndig_in = ndig_ff - NDIG_W'(1);
            end else begin
               // One byte beyond the digits is kept for the terminator.
               fail_in = (len_ff == '0) ||
                         ((LEN_W'(ndig_ff) + LEN_W'(1)) > len_ff);
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
               ndig_in = ndig_ff - NDIG_W'(1);
            end
         end
         default: begin
            bin_in = bin_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      ndig_ff <= ndig_in;
      len_ff  <= len_in;
      fail_ff <= fail_in;
   end

endmodule

// ===== hdl/bda_checker.sv =====
// ----------------------------------------------------------------------------
// bda_checker: port-level checks for the decimal ASCII converter
// Watches the request and result channels and flags results that break the
// output format or the one-request-at-a-time behavior.
// ----------------------------------------------------------------------------
module bda_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic [bda_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [0:0]                         rsp_tuser,
   input logic                               rsp_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready
);
   import bda_pkg::*;

   // A stalled result holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // No new request is taken while results are pending.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while results pending");

   // A failure result is a single, final item with a zero character.
   a_fail_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == '0))
      else $error("malformed failure result");

   // A good result carries an ASCII decimal digit.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata[CHAR_W-1:0] >= ASCII_ZERO) &&
         (rsp_tdata[CHAR_W-1:0] <= ASCII_ZERO + CHAR_W'(9)) &&
         (rsp_tdata[RSP_DATA_W-1:CHAR_W] == '0))
      else $error("digit out of range");

   // After the final result the block takes requests again.
   a_return_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("not ready after final result");

endmodule

bind binary_to_decimal_ascii_unit bda_checker u_bda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
